// File: design/b64sc_pkg.sv
// Shared types, codes and symbol mapping functions for the base64 stream codec.
package b64sc_pkg;

  // Direction register codes
  localparam logic DIR_ENC = 1'b0;
  localparam logic DIR_DEC = 1'b1;

  // Result queue depth and count width
  localparam int unsigned QDEPTH = 3;
  localparam int unsigned QCNT_W = 2;

  // Group position codes
  localparam logic [1:0] PH_0 = 2'd0;
  localparam logic [1:0] PH_1 = 2'd1;
  localparam logic [1:0] PH_2 = 2'd2;
  localparam logic [1:0] PH_3 = 2'd3;

  // One result item
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       len_err;
  } res_t;

  // Outcome of one input item
  typedef struct packed {
    logic [1:0] num;
    res_t       res0;
    res_t       res1;
    logic [1:0] phase_nxt;
    logic [5:0] carry_nxt;
  } step_t;

  // Map a 6-bit value to its alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2b;
    end else begin
      c = 8'h2f;
    end
    return c;
  endfunction

  // Map a character to its 6-bit value; anything outside the alphabet reads as 0
  function automatic logic [5:0] sym_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h41 && c <= 8'h5a) begin
      v = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      v = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30 + 8'd52;
    end else if (c == 8'h2b) begin
      v = 8'd62;
    end else if (c == 8'h2f) begin
      v = 8'd63;
    end else begin
      v = 8'd0;
    end
    return v[5:0];
  endfunction

endpackage

// File: design/b64sc_step.sv
// Per-item encode/decode logic: results and next group state for one input item.
module b64sc_step (
  input  logic               dir,
  input  logic [1:0]         phase,
  input  logic [5:0]         carry,
  input  logic [7:0]         data,
  input  logic               last,
  output b64sc_pkg::step_t   step
);
  import b64sc_pkg::*;

  logic [5:0] v;

  assign v = sym_value(data);

  always_comb begin
    step           = '0;
    step.phase_nxt = phase;
    step.carry_nxt = carry;
    if (dir == DIR_ENC) begin
      // Encode: one or two symbols per byte, flush leftover bits on the last byte
      case (phase)
        PH_1: begin
          step.res0.data = enc_char({carry[1:0], data[7:4]});
          step.carry_nxt = {2'b00, data[3:0]};
          step.phase_nxt = PH_2;
          step.res1.data = enc_char({data[3:0], 2'b00});
          step.res1.last = 1'b1;
          step.num       = last ? 2'd2 : 2'd1;
        end
        PH_2: begin
          step.res0.data = enc_char({carry[3:0], data[7:6]});
          step.res1.data = enc_char(data[5:0]);
          step.res1.last = last;
          step.carry_nxt = 6'd0;
          step.phase_nxt = PH_0;
          step.num       = 2'd2;
        end
        default: begin
          step.res0.data = enc_char(data[7:2]);
          step.carry_nxt = {4'b0000, data[1:0]};
          step.phase_nxt = PH_1;
          step.res1.data = enc_char({data[1:0], 4'b0000});
          step.res1.last = 1'b1;
          step.num       = last ? 2'd2 : 2'd1;
        end
      endcase
    end else begin
      // Decode: emit each byte once its bits are complete; flag a lone last symbol
      case (phase)
        PH_0: begin
          step.carry_nxt    = v;
          step.phase_nxt    = PH_1;
          step.res0.last    = 1'b1;
          step.res0.len_err = 1'b1;
          step.num          = last ? 2'd1 : 2'd0;
        end
        PH_1: begin
          step.res0.data = {carry, v[5:4]};
          step.res0.last = last;
          step.carry_nxt = {2'b00, v[3:0]};
          step.phase_nxt = PH_2;
          step.num       = 2'd1;
        end
        PH_2: begin
          step.res0.data = {carry[3:0], v[5:2]};
          step.res0.last = last;
          step.carry_nxt = {4'b0000, v[1:0]};
          step.phase_nxt = PH_3;
          step.num       = 2'd1;
        end
        default: begin
          step.res0.data = {carry[1:0], v};
          step.res0.last = last;
          step.carry_nxt = 6'd0;
          step.phase_nxt = PH_0;
          step.num       = 2'd1;
        end
      endcase
    end
    // End of message returns the group state to zero
    if (last) begin
      step.phase_nxt = PH_0;
      step.carry_nxt = 6'd0;
    end
  end

endmodule

// File: design/b64sc_outq.sv
// Result queue: shift queue of three entries, takes up to two results per cycle.
module b64sc_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          push_num,
  input  b64sc_pkg::res_t     push0,
  input  b64sc_pkg::res_t     push1,
  input  logic                pop,
  output logic [1:0]          cnt,
  output b64sc_pkg::res_t     head
);
  import b64sc_pkg::*;

  res_t              q_r   [QDEPTH];
  res_t              q_nxt [QDEPTH];
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;
  logic [QCNT_W-1:0] cnt_p;

  always_comb begin
    // Advance the queue on a transfer out
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    cnt_p = cnt_r;
    if (pop) begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
      cnt_p = cnt_r - 1'b1;
    end
    // Append new results behind the remaining entries
    for (int i = 0; i < QDEPTH; i++) begin
      if (push_num != 2'd0 && QCNT_W'(i) == cnt_p) begin
        q_nxt[i] = push0;
      end
      if (push_num == 2'd2 && QCNT_W'(i) == cnt_p + 1'b1) begin
        q_nxt[i] = push1;
      end
    end
    cnt_nxt = cnt_p + push_num;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign cnt  = cnt_r;
  assign head = q_r[0];

endmodule

// File: design/base64_stream_codec_core.sv
// Top level of the byte-serial base64 encoder/decoder.
//
// Input channel (in_valid/in_stall, in_byte, in_last) carries one byte or one
// character per transfer; in_last marks the end of a message. The result
// channel (out_valid/out_stall, out_byte, out_last, out_length_error) carries
// one symbol or decoded byte per transfer. cfg_we/cfg_wdata write the
// direction (0 encode, 1 decode) and clear the group state; write it only
// while the block is empty.
// An accepted item is held in an input register, worked on in the next cycle
// and queued; its first result is offered from the result queue head once
// the item has passed the input register and the queue. An item leaves the
// input register once the three-entry result queue has room for all of its
// results, so a one-result item passes every cycle unless the receiver
// stalls; items that give two symbols are paced by the single result port.
// Reset clears the direction to encode, the group state, the input register
// and the queue. When the receiver stalls, the queue fills and the block then
// raises in_stall; nothing is lost or repeated.
module base64_stream_codec_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_length_error
);
  import b64sc_pkg::*;

  logic       dir_r;
  logic [1:0] phase_r;
  logic [5:0] carry_r;
  logic       iv_r;
  logic [7:0] ib_r;
  logic       il_r;
  step_t      step;
  logic [1:0] qcnt;
  res_t       head;
  logic       consume;
  logic       pop;
  logic [2:0] room;

  b64sc_step u_step (
    .dir   (dir_r),
    .phase (phase_r),
    .carry (carry_r),
    .data  (ib_r),
    .last  (il_r),
    .step  (step)
  );

  // Move the held item on when the queue can take all of its results
  assign room    = 3'(QDEPTH) - {1'b0, qcnt};
  assign consume = iv_r && ({1'b0, step.num} <= room);
  assign in_stall = iv_r && !consume;
  assign pop      = out_valid && !out_stall;

  b64sc_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_num (consume ? step.num : 2'd0),
    .push0    (step.res0),
    .push1    (step.res1),
    .pop      (pop),
    .cnt      (qcnt),
    .head     (head)
  );

  // Input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      iv_r <= 1'b1;
    end else if (consume) begin
      iv_r <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ib_r <= in_byte;
      il_r <= in_last;
    end
  end

  // Direction register and group state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r   <= DIR_ENC;
      phase_r <= PH_0;
      carry_r <= '0;
    end else if (cfg_we) begin
      dir_r   <= cfg_wdata;
      phase_r <= PH_0;
      carry_r <= '0;
    end else if (consume) begin
      phase_r <= step.phase_nxt;
      carry_r <= step.carry_nxt;
    end
  end

  assign out_valid        = (qcnt != 2'd0);
  assign out_byte         = head.data;
  assign out_last         = head.last;
  assign out_length_error = head.len_err;

endmodule

// File: bench/base64_stream_codec_core_tb.sv
// Self-checking testbench for the byte-serial base64 encoder/decoder core.
`timescale 1ns / 100ps

module base64_stream_codec_core_tb;
  import b64sc_pkg::*;

  localparam int RESET_CYCLES  = 11;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 6;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_length_error;

  base64_stream_codec_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .out_length_error (out_length_error)
  );

  string alphabet_str = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // Codec state as the bench sees it
  logic       dir_q;
  logic [1:0] phase_q;
  logic [5:0] carry_q;
  res_t       awaited_codes[$];

  // Stimulus controls
  logic cur_dir;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_request;
  int   fail_count;
  int   cycle_count;

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic logic [7:0] b64_symbol(input logic [5:0] v);
    return alphabet_str[v];
  endfunction

  // Characters outside the alphabet decode to zero
  function automatic logic [5:0] b64_value(input logic [7:0] c);
    logic [5:0] v;
    v = '0;
    for (int i = 0; i < 64; i++) begin
      if (alphabet_str[i] == c) v = i[5:0];
    end
    return v;
  endfunction

  function automatic void expect_result(input logic [7:0] d, input logic l, input logic e);
    res_t r;
    r.data = d;
    r.last = l;
    r.len_err = e;
    awaited_codes.push_back(r);
  endfunction

  // Advance the codec state by one accepted item and queue its results
  function automatic void transcode_item(input logic [7:0] b, input logic l);
    logic [5:0] v;
    v = b64_value(b);
    if (dir_q == DIR_ENC) begin
      case (phase_q)
        PH_1: begin
          expect_result(b64_symbol({carry_q[1:0], b[7:4]}), 1'b0, 1'b0);
          carry_q = {2'b00, b[3:0]};
          phase_q = PH_2;
          if (l) expect_result(b64_symbol({carry_q[3:0], 2'b00}), 1'b1, 1'b0);
        end
        PH_2: begin
          expect_result(b64_symbol({carry_q[3:0], b[7:6]}), 1'b0, 1'b0);
          expect_result(b64_symbol(b[5:0]), l, 1'b0);
          carry_q = '0;
          phase_q = PH_0;
        end
        default: begin
          // group start; phase three never arises here and behaves the same
          expect_result(b64_symbol(b[7:2]), 1'b0, 1'b0);
          carry_q = {4'b0000, b[1:0]};
          phase_q = PH_1;
          if (l) expect_result(b64_symbol({carry_q[1:0], 4'b0000}), 1'b1, 1'b0);
        end
      endcase
    end else begin
      case (phase_q)
        PH_0: begin
          carry_q = v;
          phase_q = PH_1;
          // a lone trailing symbol cannot make a byte
          if (l) expect_result(8'h00, 1'b1, 1'b1);
        end
        PH_1: begin
          expect_result({carry_q, v[5:4]}, l, 1'b0);
          carry_q = {2'b00, v[3:0]};
          phase_q = PH_2;
        end
        PH_2: begin
          expect_result({carry_q[3:0], v[5:2]}, l, 1'b0);
          carry_q = {4'b0000, v[1:0]};
          phase_q = PH_3;
        end
        default: begin
          expect_result({carry_q[1:0], v}, l, 1'b0);
          carry_q = '0;
          phase_q = PH_0;
        end
      endcase
    end
    if (l) begin
      phase_q = PH_0;
      carry_q = '0;
    end
  endfunction

  // Watch register writes and both channels; check each result transfer
  always @(posedge clk) begin : monitor
    res_t got;
    res_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {out_byte, out_last, out_length_error};
        if (awaited_codes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: expected none, actual byte %h last %b error %b",
                   $time, got.data, got.last, got.len_err);
        end else begin
          want = awaited_codes.pop_front();
          if (got.data !== want.data) begin
            fail_count++;
            $display("%0t: out_byte expected %h actual %h", $time, want.data, got.data);
          end
          if (got.last !== want.last) begin
            fail_count++;
            $display("%0t: out_last expected %b actual %b", $time, want.last, got.last);
          end
          if (got.len_err !== want.len_err) begin
            fail_count++;
            $display("%0t: out_length_error expected %b actual %b",
                     $time, want.len_err, got.len_err);
          end
        end
      end
      if (cfg_we) begin
        dir_q = cfg_wdata;
        phase_q = PH_0;
        carry_q = '0;
      end
      if (in_valid && !in_stall) transcode_item(in_byte, in_last);
    end
  end

  // Receiver: random stall, or a long hold when requested
  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        for (int h = 0; h < HOLD_CYCLES; h++) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** base64_stream_codec_core: FAILED **");
      $finish;
    end
  end

  // Offer one item, idling for random cycles first, and hold it until the transfer
  task automatic send_item(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_item(s[k], k == s.len() - 1);
  endtask

  // Drop valid and wait until every queued result has come out
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_direction(input logic d);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    cur_dir = d;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] random_input();
    if (cur_dir == DIR_DEC && $urandom_range(99) < 85)
      return alphabet_str[$urandom_range(63)];
    return 8'($urandom_range(255));
  endfunction

  // Encode tails of every length, all-zero and all-one bytes
  task automatic test_encode_edges();
    send_idle_pct = 31;
    recv_idle_pct = 62;
    set_direction(DIR_ENC);
    send_item(8'h00, 1'b1);
    send_item(8'hff, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b1);
    send_item(8'hff, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h80, 1'b1);
    send_item(8'h7f, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'hfe, 1'b0);
    send_item(8'h3c, 1'b1);
  endtask

  // Decode every symbol count mod 4, bad lengths and characters outside the alphabet
  task automatic test_decode_edges();
    set_direction(DIR_DEC);
    send_text("A");
    send_text("//");
    send_text("+/9");
    send_text("Za0z");
    send_text("zzzz/");
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h40, 1'b0);
    send_item(8'h5b, 1'b1);
    send_item(8'h60, 1'b0);
    send_item(8'h7b, 1'b0);
    send_item(8'h2e, 1'b0);
    send_item(8'h3a, 1'b0);
    send_item(8'h2c, 1'b1);
  endtask

  // Random messages in both directions, some cut off by a direction write
  task automatic test_random_traffic(input int s_pct, input int r_pct, input int n_items);
    int  sent;
    int  len;
    bit  cut_off;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(5) == 0) set_direction(1'($urandom_range(1)));
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 9);
      cut_off = ($urandom_range(11) == 0);
      for (int k = 0; k < len; k++) send_item(random_input(), (k == len - 1) && !cut_off);
      if (cut_off) set_direction(1'($urandom_range(1)));
      sent += len;
    end
  endtask

  // Hold the receiver off while the sender streams back to back, then drain
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_direction(DIR_ENC);
    hold_request = 1'b1;
    for (int k = 0; k < 48; k++) send_item(8'($urandom_range(255)), k % 16 == 15);
    wait_drain();
    set_direction(DIR_DEC);
    hold_request = 1'b1;
    for (int k = 0; k < 40; k++) send_item(random_input(), k % 10 == 9);
    wait_drain();
  endtask

  initial begin
    in_valid      = 1'b0;
    in_byte       = 8'h00;
    in_last       = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = DIR_ENC;
    rst_n         = 1'b0;
    hold_request  = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fail_count    = 0;
    cycle_count   = 0;
    cur_dir       = DIR_ENC;
    dir_q         = DIR_ENC;
    phase_q       = PH_0;
    carry_q       = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_encode_edges();
    test_decode_edges();
    test_random_traffic(31, 62, 260);
    test_random_traffic(62, 31, 260);
    test_random_traffic(0, 0, 260);
    test_backpressure();

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaited_codes.size() == 0) begin
      $display("** base64_stream_codec_core: PASSED **");
    end else begin
      $display("** base64_stream_codec_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: base64_stream_codec_core.f
design/b64sc_pkg.sv
design/b64sc_step.sv
design/b64sc_outq.sv
design/base64_stream_codec_core.sv
bench/base64_stream_codec_core_tb.sv
